// ===== rtl/core/chacha20_keystream_xor_macros.svh =====
// Assertion macros for the ChaCha20 keystream XOR block.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ckx_pkg.sv =====
// Shared types, constants and the half quarter-round function of the
// ChaCha20 keystream XOR block. No dependencies.
package ckx_pkg;

    localparam int CFG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int POS_W      = 6;
    localparam int Q_DEPTH    = 4;
    localparam int ROUNDS_DEF = 20;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_KEY_0     = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_1     = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY_2     = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_3     = 3'd3;
    localparam logic [IDX_W-1:0] REG_NONCE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_CTR = 3'd5;

    localparam logic [POS_W-1:0] POS_FIRST = 6'd0;
    localparam logic [POS_W-1:0] POS_LAST  = 6'd63;

    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef logic [15:0][31:0] word16_t;
    typedef logic [3:0][31:0]  quad_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       out_last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;
    } q_entry_t;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic        ctr_load;
        logic [63:0] value;
    } cfg_evt_t;

    typedef struct packed {
        logic start;
        logic abort;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef struct packed {
        logic nxt_valid;
        logic start;
    } back_stat_t;

    // First or second half of a quarter round: two add, xor, rotate steps.
    // Element 0 is a, 1 is b, 2 is c, 3 is d.
    function automatic quad_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d,
                                      input logic second);
        logic [31:0] a1;
        logic [31:0] dx;
        logic [31:0] d1;
        logic [31:0] c1;
        logic [31:0] bx;
        logic [31:0] b1;
        quad_t       res;
        a1 = a + b;
        dx = d ^ a1;
        d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = c + d1;
        bx = b ^ c1;
        b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        res[0] = a1;
        res[1] = b1;
        res[2] = c1;
        res[3] = d1;
        return res;
    endfunction

endpackage

// ===== rtl/core/ckx_fifo.sv =====
// Short word queue between the front and the back of the block.
// Depends on ckx_pkg.
module ckx_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ckx_pkg::q_entry_t wr_entry,
    input  logic              pop,
    output ckx_pkg::q_entry_t head,
    output logic              full,
    output logic              empty
);
    import ckx_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    q_entry_t      mem [Q_DEPTH];
    logic [AW:0]   wr_ptr_reg;
    logic [AW:0]   wr_ptr_next;
    logic [AW:0]   rd_ptr_reg;
    logic [AW:0]   rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]) &&
                   (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign head  = mem[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (AW+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (AW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/ckx_front.sv =====
// Input side: accepts words, tracks the byte position within the block
// and tags each word for the queue. Depends on ckx_pkg.
module ckx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ckx_pkg::in_word_t in_word,
    input  logic              ctr_load,
    input  logic              q_full,
    output logic              q_push,
    output ckx_pkg::q_entry_t q_entry
);
    import ckx_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign q_entry.data = in_word.data_in;
    assign q_entry.last = in_word.end_of_buffer;
    assign q_entry.pos  = pos_reg;

    // A block ends after its last byte or after a byte that closes a buffer; a counter load also restarts the position.
    always_comb
    begin
        pos_next = pos_reg;
        if (ctr_load)
        begin
            pos_next = POS_FIRST;
        end
        else if (q_push)
        begin
            if (pos_reg == POS_LAST || in_word.end_of_buffer)
            begin
                pos_next = POS_FIRST;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== rtl/core/ckx_core.sv =====
// ChaCha block function: one half quarter-round on all four columns or
// diagonals per cycle, then the feed-forward add. Depends on ckx_pkg.
module ckx_core #(
    parameter int ROUNDS = ckx_pkg::ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ckx_pkg::core_ctl_t  ctl,
    input  ckx_pkg::word16_t    init,
    output ckx_pkg::core_stat_t stat,
    output ckx_pkg::word16_t    ks
);
    import ckx_pkg::*;

    // Odd round counts round up to whole double rounds.
    localparam int STEPS  = 4 * ((ROUNDS + 1) / 2);
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_RUN  = 2'd1;
    localparam logic [1:0] CS_ADD  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    word16_t           work_reg;
    word16_t           work_next;
    word16_t           init_reg;
    word16_t           ks_reg;
    logic              half;
    logic              diag;

    assign half = step_reg[0];
    assign diag = step_reg[1];

    assign stat.busy = (state_reg != CS_IDLE);
    assign stat.done = (state_reg == CS_ADD) && !ctl.abort;
    assign ks        = ks_reg;

    always_comb
    begin
        quad_t res;
        work_next = work_reg;
        for (int q = 0; q < 4; q++)
        begin
            if (!diag)
            begin
                res = qr_half(work_reg[q], work_reg[4 + q], work_reg[8 + q],
                              work_reg[12 + q], half);
                work_next[q]      = res[0];
                work_next[4 + q]  = res[1];
                work_next[8 + q]  = res[2];
                work_next[12 + q] = res[3];
            end
            else
            begin
                res = qr_half(work_reg[q], work_reg[4 + ((q + 1) & 3)],
                              work_reg[8 + ((q + 2) & 3)],
                              work_reg[12 + ((q + 3) & 3)], half);
                work_next[q]                  = res[0];
                work_next[4 + ((q + 1) & 3)]  = res[1];
                work_next[8 + ((q + 2) & 3)]  = res[2];
                work_next[12 + ((q + 3) & 3)] = res[3];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = CS_RUN;
                    step_next  = '0;
                end
            end
            CS_RUN:
            begin
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = CS_ADD;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            CS_ADD:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        if (ctl.abort)
        begin
            state_next = CS_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CS_IDLE && ctl.start)
        begin
            work_reg <= init;
            init_reg <= init;
        end
        else if (state_reg == CS_RUN)
        begin
            work_reg <= work_next;
        end
        if (state_reg == CS_ADD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= work_reg[i] + init_reg[i];
            end
        end
    end

endmodule

// ===== rtl/core/ckx_back.sv =====
// Output side: owns the block counter, keeps the current and the next
// keystream block, XORs queued words and holds the output register.
// Depends on ckx_pkg and ckx_core.
module ckx_back #(
    parameter int ROUNDS = ckx_pkg::ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ckx_pkg::cfg_t       cfg,
    input  ckx_pkg::cfg_evt_t   evt,
    input  ckx_pkg::q_entry_t   head,
    input  logic                q_empty,
    output logic                q_pop,
    output ckx_pkg::back_stat_t bstat,
    output logic                out_valid,
    input  logic                out_ready,
    output ckx_pkg::out_word_t  out_word
);
    import ckx_pkg::*;

    logic [63:0] ctr_reg;
    logic        nxt_valid_reg;
    word16_t     cur_ks_reg;
    word16_t     nxt_ks;
    word16_t     init;
    out_word_t   out_reg;
    logic        out_valid_reg;
    core_ctl_t   cctl;
    core_stat_t  cstat;
    logic        can_out;
    logic        first;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init[i]         = SIGMA[i];
            init[4 + 2 * i] = cfg.key[i][31:0];
            init[5 + 2 * i] = cfg.key[i][63:32];
        end
        init[12] = ctr_reg[31:0];
        init[13] = ctr_reg[63:32];
        init[14] = cfg.nonce[31:0];
        init[15] = cfg.nonce[63:32];
    end

    // The core runs ahead on the next counter value whenever the next
    // block slot is empty and the core is idle; a write to a listed register restarts it.
    assign cctl.start = !nxt_valid_reg && !cstat.busy && !evt.hit;
    assign cctl.abort = evt.hit;

    ckx_core #(
        .ROUNDS (ROUNDS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .init  (init),
        .stat  (cstat),
        .ks    (nxt_ks)
    );

    assign first   = (head.pos == POS_FIRST);
    assign can_out = !out_valid_reg || out_ready;
    assign q_pop   = !q_empty && can_out && (!first || nxt_valid_reg);

    assign ks_word = first ? nxt_ks[0] : cur_ks_reg[head.pos[5:2]];

    always_comb
    begin
        case (head.pos[1:0])
            2'd0:    ks_byte = ks_word[7:0];
            2'd1:    ks_byte = ks_word[15:8];
            2'd2:    ks_byte = ks_word[23:16];
            default: ks_byte = ks_word[31:24];
        endcase
    end

    assign bstat.nxt_valid = nxt_valid_reg;
    assign bstat.start     = cctl.start;
    assign out_valid       = out_valid_reg;
    assign out_word        = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= '0;
            nxt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ctr_load)
            begin
                ctr_reg <= evt.value;
            end
            else if (q_pop && first)
            begin
                ctr_reg <= ctr_reg + 64'd1;
            end

            if (evt.hit || (q_pop && first))
            begin
                nxt_valid_reg <= 1'b0;
            end
            else if (cstat.done)
            begin
                nxt_valid_reg <= 1'b1;
            end

            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && first)
        begin
            cur_ks_reg <= nxt_ks;
        end
        if (q_pop)
        begin
            out_reg.data_out <= head.data ^ ks_byte;
            out_reg.out_last <= head.last;
        end
    end

endmodule

// ===== rtl/core/chacha20_keystream_xor.sv =====
// Top level of the ChaCha20 (64-bit nonce) keystream XOR block.
// Depends on ckx_pkg, ckx_front, ckx_fifo, ckx_back and the macro header.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_ready    in_word  (data_in, end_of_buffer)
//  out       source     out_valid/out_ready  out_word (data_out, out_last)
//  cfg       sink       cfg_we               cfg_idx, cfg_data
//
// Words flow at one per cycle while a keystream block is on hand and the
// receiver is ready. The block core works one half quarter-round per cycle
// and computes the next block while the current one is used, so only the
// first word of a block can wait on it.
// After reset, and after any write to a listed register, the first word of a
// block may wait for a whole block computation. Buffers ending early in a
// block shorten the time to hide the core, so the first word of the next
// block may stall for the remainder.
// A four-entry queue between input and output lets either side stall alone.
`include "chacha20_keystream_xor_macros.svh"

module chacha20_keystream_xor #(
    parameter int ROUNDS = ckx_pkg::ROUNDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ckx_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ckx_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [ckx_pkg::IDX_W-1:0]        cfg_idx,
    input  logic [ckx_pkg::CFG_W-1:0]        cfg_data
);
    import ckx_pkg::*;

    // Configuration registers. The start counter itself lives in the back
    // part, where it becomes the running block counter.
    logic [3:0][63:0] key_reg;
    logic [63:0]      nonce_reg;
    cfg_t             cfg;
    cfg_evt_t         evt;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    q_entry_t   q_entry;
    q_entry_t   q_head;
    back_stat_t bstat;

    assign cfg.key   = key_reg;
    assign cfg.nonce = nonce_reg;

    // Writes beyond the register list change nothing and do not disturb
    // the block core.
    assign evt.hit      = cfg_we && (cfg_idx inside {[REG_KEY_0:REG_START_CTR]});
    assign evt.ctr_load = cfg_we && (cfg_idx == REG_START_CTR);
    assign evt.value    = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KEY_0: key_reg[0] <= cfg_data;
                REG_KEY_1: key_reg[1] <= cfg_data;
                REG_KEY_2: key_reg[2] <= cfg_data;
                REG_KEY_3: key_reg[3] <= cfg_data;
                REG_NONCE: nonce_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The front tags each word with its byte position in the block.
    ckx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .ctr_load (evt.ctr_load),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ckx_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_entry),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // The back pairs each tagged word with its keystream byte.
    ckx_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt       (evt),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .bstat     (bstat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    `CKX_ASSERT_IMP(a_block_ready, q_pop && (q_head.pos == POS_FIRST), bstat.nxt_valid, "block start word used a keystream block that was not ready")
    `CKX_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "word taken from an empty queue")
    `CKX_ASSERT_NEXT(a_ctr_load_pos, evt.ctr_load, q_entry.pos == POS_FIRST, "counter load did not restart the byte position")
    `CKX_ASSERT_NEXT(a_start_clears, evt.hit, !bstat.nxt_valid, "register write left a stale keystream block")
    `CKX_ASSERT_IMP(a_start_slot_free, bstat.start, !bstat.nxt_valid && !evt.hit, "block core started while the next block slot was taken")

endmodule

// ===== tb/chacha_tb_pkg.sv =====
// Scoreboard and shared test constants for the ChaCha20 keystream XOR testbench.
// Depends on ckx_pkg for the word types and register indexes.
package chacha_tb_pkg;

    import ckx_pkg::*;

    localparam int ROUND_COUNT = 20;
    localparam int MAX_REPORTS = 100;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} ready_mode_e;

    class chacha_xor_scoreboard;
        logic [63:0] key_part [4];
        logic [63:0] nonce;
        logic [63:0] block_ctr;
        logic [5:0]  byte_pos;
        logic [31:0] ks_word [16];
        logic [31:0] mix [16];
        out_word_t   expected_bytes [$];
        int          mismatches;
        int          blocks_made;
        int          bytes_checked;

        function new();
            foreach (key_part[i]) key_part[i] = '0;
            foreach (ks_word[i]) ks_word[i] = '0;
            nonce         = '0;
            block_ctr     = '0;
            byte_pos      = POS_FIRST;
            mismatches    = 0;
            blocks_made   = 0;
            bytes_checked = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_KEY_0:     key_part[0] = value;
                REG_KEY_1:     key_part[1] = value;
                REG_KEY_2:     key_part[2] = value;
                REG_KEY_3:     key_part[3] = value;
                REG_NONCE:     nonce = value;
                REG_START_CTR:
                begin
                    block_ctr = value;
                    byte_pos  = POS_FIRST;
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] = mix[a] + mix[b];
            mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] = mix[c] + mix[d];
            mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] = mix[a] + mix[b];
            mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] = mix[c] + mix[d];
            mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        // One 64-byte keystream block from the current key, counter and nonce.
        function void generate_block();
            logic [31:0] seed [16];
            seed[0] = 32'h61707865;
            seed[1] = 32'h3320646e;
            seed[2] = 32'h79622d32;
            seed[3] = 32'h6b206574;
            for (int i = 0; i < 4; i++)
            begin
                seed[4 + 2 * i] = key_part[i][31:0];
                seed[5 + 2 * i] = key_part[i][63:32];
            end
            seed[12] = block_ctr[31:0];
            seed[13] = block_ctr[63:32];
            seed[14] = nonce[31:0];
            seed[15] = nonce[63:32];
            mix = seed;
            // Double rounds only, so an odd count rounds up.
            for (int r = 0; r < ROUND_COUNT; r += 2)
            begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            foreach (ks_word[i]) ks_word[i] = mix[i] + seed[i];
            blocks_made++;
        endfunction

        function void note_plain_word(in_word_t w);
            logic [7:0] ks_byte;
            out_word_t  want;
            if (byte_pos == POS_FIRST)
                generate_block();
            ks_byte = 8'(ks_word[byte_pos[5:2]] >> (8 * byte_pos[1:0]));
            want.data_out = w.data_in ^ ks_byte;
            want.out_last = w.end_of_buffer;
            expected_bytes.insert(expected_bytes.size(), want);
            if (byte_pos == POS_LAST || w.end_of_buffer)
            begin
                block_ctr = block_ctr + 64'd1;
                byte_pos  = POS_FIRST;
            end
            else
                byte_pos = byte_pos + 6'd1;
        endfunction

        function bit count_mismatch();
            mismatches++;
            if (mismatches == MAX_REPORTS + 1)
                $display("Further mismatches are counted but not shown.");
            return mismatches <= MAX_REPORTS;
        endfunction

        function void check_cipher_word(out_word_t got);
            out_word_t want;
            if (expected_bytes.size() == 0)
            begin
                if (count_mismatch())
                    $display("%0t: output word with nothing expected, expected none, got %h/%b",
                             $time, got.data_out, got.out_last);
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got.data_out !== want.data_out && count_mismatch())
                $display("%0t: data_out mismatch, expected %h, got %h",
                         $time, want.data_out, got.data_out);
            if (got.out_last !== want.out_last && count_mismatch())
                $display("%0t: out_last mismatch, expected %b, got %b",
                         $time, want.out_last, got.out_last);
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
// Self-checking testbench for chacha20_keystream_xor: random and directed words
// are checked against a ChaCha20 scoreboard. Depends on ckx_pkg and chacha_tb_pkg.
module testbench;

    import ckx_pkg::*;
    import chacha_tb_pkg::*;

    // Long enough for a full block computation behind the receiver's longest
    // hold-off, several times over.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_WORDS = 1900;
    localparam int NUM_PHASES   = 8;

    logic clk = 1'b0;
    logic rst_n;

    logic       in_valid;
    logic       in_ready;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_word;
    logic       cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    chacha_xor_scoreboard sb;

    int  stall_cycles = 0;
    int  words_sent = 0;
    int  buffers_sent = 0;
    int  reg_writes = 0;
    int  holdoffs = 0;
    int  burst_left = 0;
    int  hold_requests = 0;

    always #1 clk = ~clk;

    chacha20_keystream_xor #(
        .ROUNDS(ROUND_COUNT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Both handshakes are sampled at the rising edge in one process, input
    // first, so a word that could pass straight through is still predicted
    // before it is checked. The same process runs the watchdog: it counts
    // edges at which neither channel moves a word.
    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_plain_word(in_word);
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                sb.check_cipher_word(out_word);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d still expected",
                         $time, STALL_LIMIT, sb.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The receiver stalls on its own pattern: stretches of random length, each
    // in one mode. When the stimulus asks for back-pressure it holds ready low
    // for a long counted stretch so the internal queue fills and the input
    // stalls.
    initial
    begin : receiver
        ready_mode_e mode;
        int stretch_left;
        int hold_left;
        int tick;
        out_ready    = 1'b0;
        mode         = RX_ALWAYS;
        stretch_left = 0;
        hold_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (holdoffs < hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holdoffs++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode         = ready_mode_e'($urandom_range(0, 3));
                    stretch_left = $urandom_range(5, 80);
                end
                stretch_left--;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // Offers one word from the falling edge on and holds it until it is taken.
    // Valid stays high when the next word follows straight away.
    task automatic send_word(input logic [7:0] data, input logic last);
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= '{data_in: data, end_of_buffer: last};
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Idle cycles on the input; the payload is scrambled while valid is low.
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_word  <= '{data_in: 8'($urandom_range(0, 255)),
                          end_of_buffer: 1'($urandom_range(0, 1))};
        end
    endtask

    // Bursts of random length separated by random gaps; some bursts are long
    // enough to run through several whole blocks with no gap at all.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pause_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 20);
        end
    endtask

    // A buffer call: random bytes with the end marker on the last one only.
    task automatic send_buffer(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
            pace_sender();
        end
        buffers_sent++;
    endtask

    // Stops offering words and waits for every expected word to come out.
    task automatic wait_drain();
        pause_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Registers are only written with the datapath empty, so the scoreboard can
    // take the new value at once.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, value);
        reg_writes++;
    endtask

    // Register values lean toward the extremes and the 32-bit carry points.
    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h0000_0000_FFFF_FFFF;
            3: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin : stimulus
        int phase_end;
        int kind;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        sb       = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All-zero key, nonce and counter straight out of reset. The third
        // word ends a buffer in mid-block, so the fourth starts block one.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);
        send_word(8'h5A, 1'b0);
        wait_drain();

        // All-ones everywhere; two one-word buffers take the counter from its
        // maximum through the wrap to zero.
        write_reg(REG_KEY_0, '1);
        write_reg(REG_KEY_1, '1);
        write_reg(REG_KEY_2, '1);
        write_reg(REG_KEY_3, '1);
        write_reg(REG_NONCE, '1);
        write_reg(REG_START_CTR, '1);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        send_word(8'h3C, 1'b0);
        send_word(8'hC3, 1'b0);
        wait_drain();

        // Key and nonce change in mid-block: the rest of this block keeps the
        // old keystream, the next block uses the new values.
        write_reg(REG_KEY_0, {$urandom, $urandom});
        write_reg(REG_NONCE, '0);
        send_word(8'h81, 1'b0);
        send_word(8'h7E, 1'b1);
        send_word(8'h18, 1'b0);
        wait_drain();

        // Writes past the register list must leave everything as it was,
        // including the position inside the current block.
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        send_word(8'hE7, 1'b0);
        wait_drain();

        // Loading the counter in mid-block restarts at byte zero; the second
        // buffer then carries from the low counter word into the high one.
        write_reg(REG_START_CTR, 64'h0000_0000_FFFF_FFFF);
        send_word(8'h24, 1'b1);
        send_word(8'hDB, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drain();
            for (int idx = REG_KEY_0; idx <= REG_START_CTR; idx++)
                if (phase == 0 || $urandom_range(0, 3) != 0)
                    write_reg(IDX_W'(idx), pick_reg_value());
            phase_end = words_sent + RANDOM_WORDS / NUM_PHASES;

            // Back-pressure: the receiver holds off while a gapless burst keeps
            // coming, so the queue fills and the input has to stall.
            if (phase == 1 || phase == NUM_PHASES - 3)
            begin
                hold_requests++;
                for (int i = 0; i < 48; i++)
                    send_word(8'($urandom_range(0, 255)), i % 16 == 15);
            end

            while (words_sent < phase_end)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 15)
                    send_buffer(($urandom_range(0, 7) == 0) ? $urandom_range(65, 200)
                                                             : $urandom_range(1, 64));
                else if (kind < 18)
                begin
                    // Noise: end markers at random.
                    repeat ($urandom_range(1, 12))
                    begin
                        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        pace_sender();
                    end
                end
                else if (kind == 18)
                begin
                    // A buffer with no end marker, wrapping blocks at byte 63.
                    repeat ($urandom_range(2, 90))
                    begin
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                        pace_sender();
                    end
                end
                else
                begin
                    // Register change while the stream may sit in mid-block.
                    wait_drain();
                    if ($urandom_range(0, 4) == 0)
                        write_reg(IDX_W'(REG_SPARE_6 + $urandom_range(0, 1)),
                                  pick_reg_value());
                    else
                        write_reg(IDX_W'($urandom_range(REG_KEY_0, REG_NONCE)),
                                  pick_reg_value());
                end
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d words (%0d marked buffers) over %0d keystream blocks.",
                 sb.bytes_checked, buffers_sent, sb.blocks_made);
        $display("Used %0d register writes and %0d long receiver hold-offs.",
                 reg_writes, holdoffs);
        if (sb.pending() != 0)
            $display("%0t: %0d expected words never came out", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ckx_pkg.sv
rtl/core/ckx_fifo.sv
rtl/core/ckx_front.sv
rtl/core/ckx_core.sv
rtl/core/ckx_back.sv
rtl/core/chacha20_keystream_xor.sv
tb/chacha_tb_pkg.sv
tb/testbench.sv
